FILE: rtl/core/hcse_pkg.sv
// Shared types, constants and the Hall code table for the Hall speed estimator.
package hcse_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int COEFF_W = 20;
    localparam int ALPHA_W = 16;
    localparam int SPEED_W = 16;

    localparam logic [COEFF_W-1:0] SPEED_COEFF_RST = 20'd120000;
    localparam logic [ALPHA_W-1:0] COUNT_ALPHA_RST = 16'd9037;
    localparam logic [ALPHA_W-1:0] SPEED_ALPHA_RST = 16'd15591;

    localparam logic [1:0] CFG_SPEED_COEFF = 2'd0;
    localparam logic [1:0] CFG_COUNT_ALPHA = 2'd1;
    localparam logic [1:0] CFG_SPEED_ALPHA = 2'd2;

    localparam logic [2:0] STEP_Q41  = 3'd0;
    localparam logic [2:0] STEP_Q16  = 3'd1;
    localparam logic [2:0] STEP_Q63  = 3'd2;
    localparam logic [2:0] STEP_Q32  = 3'd3;
    localparam logic [2:0] STEP_Q25  = 3'd4;
    localparam logic [2:0] STEP_Q54  = 3'd5;
    localparam logic [2:0] STEP_STOP = 3'd6;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_DIV = 2'b10
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    function automatic logic [2:0] step_of_code(input logic [2:0] code);
        logic [2:0] step;
        unique case (code)
            3'd5:    step = STEP_Q41;
            3'd1:    step = STEP_Q16;
            3'd3:    step = STEP_Q63;
            3'd2:    step = STEP_Q32;
            3'd6:    step = STEP_Q25;
            3'd4:    step = STEP_Q54;
            default: step = STEP_STOP;
        endcase
        return step;
    endfunction

endpackage

FILE: rtl/core/hall_commutation_speed_estimator_top.sv
// Top level of the Hall six-step commutation and speed estimator.
//
// Channel   Direction  Transaction
// s_axis    in         tdata: hall_u, hall_v, hall_w (one Hall sample)
// m_axis    out        tdata: hall_code, drive_step, raw_speed, smoothed_speed
// cfg       in         write enable, register index, data (no handshake)
//
// A sample without a rising U edge goes to S_OUT and then into the output register.
// A rising U edge first passes S_CF_MUL, S_DIV and S_SF_MUL, where two 16-bit
// multiplications and one 20 + FRAC_BITS bit division share one shift-add unit.
// Reset is synchronous and clears the state and configuration to defaults.
// A stalled result waits in the output register; the next sample is taken meanwhile.
module hall_commutation_speed_estimator_top
    import hcse_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // hall_u, hall_v, hall_w, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hall_code, drive_step, raw_speed,
                                        // smoothed_speed, zero fill
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int CFW = COUNT_BITS + FRAC_BITS;
    localparam int SFW = SPEED_W + FRAC_BITS;
    localparam int VW  = FRAC_BITS + ((COUNT_BITS > 16) ? COUNT_BITS : 16);
    localparam int NQ  = COEFF_W + FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CF_MUL = 5'b00010,
        S_DIV    = 5'b00100,
        S_SF_MUL = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state               r_state;
    logic [COEFF_W-1:0]   r_coeff;
    logic [ALPHA_W-1:0]   r_count_alpha;
    logic [ALPHA_W-1:0]   r_speed_alpha;
    logic                 r_last_u;
    logic [COUNT_BITS-1:0] r_tick;
    logic [CFW-1:0]       r_cf;
    logic [SFW-1:0]       r_ss;
    logic [SPEED_W-1:0]   r_raw;
    logic                 r_dir;
    logic [2:0]           r_code;
    logic [2:0]           r_step;
    logic                 r_out_valid;
    logic [39:0]          r_out_data;

    logic                 w_accept;
    logic                 w_u;
    logic                 w_rise;
    logic                 w_load;
    logic [CFW-1:0]       w_cnt_x;
    logic                 w_cf_ge;
    logic [CFW-1:0]       w_cf_mag;
    logic [CFW-1:0]       w_cf_new;
    logic [SPEED_W-1:0]   w_quot_sat;
    logic [SFW-1:0]       w_sp_x;
    logic                 w_sp_ge;
    logic [SFW-1:0]       w_sp_mag;
    logic [SFW-1:0]       w_ss_new;
    logic [SPEED_W-1:0]   w_raw_out;
    t_alu_cmd             w_cmd;
    logic [VW-1:0]        w_mag;
    logic [ALPHA_W-1:0]   w_alpha;
    logic                 w_done;
    logic [VW-1:0]        w_delta;
    logic [NQ-1:0]        w_quot;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_u           = s_axis_tdata[0];
    assign w_rise        = w_u && !r_last_u;
    assign w_load        = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    assign w_cnt_x  = CFW'(r_tick) << FRAC_BITS;
    assign w_cf_ge  = (w_cnt_x >= r_cf);
    assign w_cf_mag = w_cf_ge ? (w_cnt_x - r_cf) : (r_cf - w_cnt_x);
    assign w_cf_new = r_dir ? (r_cf + CFW'(w_delta)) : (r_cf - CFW'(w_delta));

    assign w_quot_sat = (|w_quot[NQ-1:SPEED_W]) ? '1 : w_quot[SPEED_W-1:0];
    assign w_sp_x     = SFW'(w_quot_sat) << FRAC_BITS;
    assign w_sp_ge    = (w_sp_x >= r_ss);
    assign w_sp_mag   = w_sp_ge ? (w_sp_x - r_ss) : (r_ss - w_sp_x);
    assign w_ss_new   = r_dir ? (r_ss + SFW'(w_delta)) : (r_ss - SFW'(w_delta));

    assign w_raw_out = (r_step == STEP_STOP) ? '0 : r_raw;

    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.op    = ALU_MUL;
        w_mag       = VW'(w_cf_mag);
        w_alpha     = r_count_alpha;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.start = w_accept && w_rise;
            end
            S_CF_MUL: begin
                w_cmd.start = w_done;
                w_cmd.op    = ALU_DIV;
            end
            S_DIV: begin
                w_cmd.start = w_done;
                w_mag       = VW'(w_sp_mag);
                w_alpha     = r_speed_alpha;
            end
            default: begin
                w_cmd.start = 1'b0;
            end
        endcase
    end

    hcse_alu #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_mag   (w_mag),
        .i_alpha (w_alpha),
        .i_num   (NQ'(r_coeff) << FRAC_BITS),
        .i_den   (w_cf_new),
        .o_done  (w_done),
        .o_delta (w_delta),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff       <= SPEED_COEFF_RST;
            r_count_alpha <= COUNT_ALPHA_RST;
            r_speed_alpha <= SPEED_ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED_COEFF: r_coeff       <= i_cfg_data;
                CFG_COUNT_ALPHA: r_count_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_SPEED_ALPHA: r_speed_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_u    <= 1'b0;
            r_tick      <= '0;
            r_cf        <= '0;
            r_ss        <= '0;
            r_raw       <= '0;
            r_out_valid <= 1'b0;
            r_dir       <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_code <= s_axis_tdata[2:0];
                        r_step <= step_of_code(s_axis_tdata[2:0]);
                        if (w_u != r_last_u) begin
                            r_last_u <= w_u;
                            r_tick   <= '0;
                        end else if (r_tick != '1) begin
                            r_tick <= r_tick + COUNT_BITS'(1);
                        end
                        if (w_rise) begin
                            r_dir   <= w_cf_ge;
                            r_state <= S_CF_MUL;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_CF_MUL: begin
                    if (w_done) begin
                        r_cf    <= w_cf_new;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_raw   <= w_quot_sat;
                        r_dir   <= w_sp_ge;
                        r_state <= S_SF_MUL;
                    end
                end
                S_SF_MUL: begin
                    if (w_done) begin
                        r_ss    <= w_ss_new;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_raw      <= w_raw_out;
                        r_out_data <= {2'b00, r_ss[FRAC_BITS +: SPEED_W], w_raw_out,
                                       r_step, r_code};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/core/hcse_alu.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module hcse_alu
    import hcse_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_alu_cmd                              i_cmd,
    input  logic [FRAC_BITS+((COUNT_BITS>16)?COUNT_BITS:16)-1:0] i_mag,
    input  logic [ALPHA_W-1:0]                    i_alpha,
    input  logic [COEFF_W+FRAC_BITS-1:0]          i_num,
    input  logic [COUNT_BITS+FRAC_BITS-1:0]       i_den,
    output logic                                  o_done,
    output logic [FRAC_BITS+((COUNT_BITS>16)?COUNT_BITS:16)-1:0] o_delta,
    output logic [COEFF_W+FRAC_BITS-1:0]          o_quot
);

    localparam int VW  = FRAC_BITS + ((COUNT_BITS > 16) ? COUNT_BITS : 16);
    localparam int AW  = VW + ALPHA_W + 1;
    localparam int NQ  = COEFF_W + FRAC_BITS;
    localparam int CW  = $clog2(NQ + 1);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     r_acc;
    logic [AW-1:0]     r_opb;
    logic [ALPHA_W-1:0] r_mplier;
    logic [NQ-1:0]     r_dq;

    logic              w_sub;
    logic [AW-1:0]     w_a;
    logic [AW-1:0]     w_b;
    logic [AW:0]       w_sum;

    assign w_sub = (r_op == ALU_DIV);
    assign w_a   = w_sub ? {r_acc[AW-2:0], r_dq[NQ-1]} : r_acc;
    assign w_b   = w_sub ? ~r_opb : (r_mplier[0] ? r_opb : '0);
    assign w_sum = {1'b0, w_a} + {1'b0, w_b} + (AW+1)'(w_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            if (i_cmd.op == ALU_MUL) begin
                r_acc    <= AW'(32768);
                r_opb    <= AW'(i_mag);
                r_mplier <= i_alpha;
                r_cnt    <= CW'(ALPHA_W);
            end else begin
                r_acc <= '0;
                r_opb <= AW'(i_den);
                r_dq  <= i_num;
                r_cnt <= CW'(NQ);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (w_sub) begin
                if (w_sum[AW]) begin
                    r_acc <= w_sum[AW-1:0];
                    r_dq  <= {r_dq[NQ-2:0], 1'b1};
                end else begin
                    r_acc <= w_a;
                    r_dq  <= {r_dq[NQ-2:0], 1'b0};
                end
            end else begin
                r_acc    <= w_sum[AW-1:0];
                r_opb    <= r_opb << 1;
                r_mplier <= r_mplier >> 1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_delta = r_acc[ALPHA_W +: VW];
    assign o_quot  = r_dq;

endmodule

FILE: test/tb_hall_commutation_speed_estimator_top.sv
// Self-checking testbench for the Hall commutation and speed estimator top level.
`timescale 1ns / 1ps

module tb_hall_commutation_speed_estimator_top;
    import hcse_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [2:0] ROTATION [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};

    typedef struct packed {
        logic [2:0]  code;
        logic [2:0]  step;
        logic [15:0] rpm;
        logic [15:0] rpm_filt;
    } t_hall_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // hall_u, hall_v, hall_w, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // hall_code, drive_step, raw_speed,
                                       // smoothed_speed, zero fill
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    logic [2:0]   hall_samples[$];
    t_hall_result expected_results[$];

    logic [19:0] coeff_reg;
    logic [15:0] count_gain;
    logic [15:0] speed_gain;
    logic        last_u_seen;
    logic [15:0] edge_ticks;
    logic [23:0] period_filt;
    logic [15:0] rpm_raw;
    logic [23:0] rpm_smooth;

    logic in_acc = 1'b0;
    logic out_acc = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   rx_hold = 0;
    int   holds_done = 0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;

    hall_commutation_speed_estimator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [23:0] smooth(input logic [23:0] y, input logic [23:0] x,
                                           input logic [15:0] alpha);
        logic [63:0] mag;
        logic [63:0] delta;
        logic [63:0] sum;
        if (x >= y) begin
            mag   = x - y;
            delta = (mag * alpha + 64'd32768) >> 16;
            sum   = y + delta;
            return (sum > 64'hFF_FFFF) ? 24'hFF_FFFF : sum[23:0];
        end
        mag   = y - x;
        delta = (mag * alpha + 64'd32768) >> 16;
        return (delta > y) ? 24'd0 : y - delta[23:0];
    endfunction

    function automatic logic [2:0] drive_step_of(input logic [2:0] code);
        case (code)
            3'd5:    return STEP_Q41;
            3'd1:    return STEP_Q16;
            3'd3:    return STEP_Q63;
            3'd2:    return STEP_Q32;
            3'd6:    return STEP_Q25;
            3'd4:    return STEP_Q54;
            default: return STEP_STOP;
        endcase
    endfunction

    function automatic t_hall_result predict_commutation(input logic [2:0] code);
        t_hall_result r;
        logic [63:0]  quot;
        if (code[0] != last_u_seen) begin
            last_u_seen = code[0];
            if (code[0]) begin
                period_filt = smooth(period_filt, {edge_ticks, 8'd0}, count_gain);
                if (period_filt == 24'd0) begin
                    quot = 64'hFFFF;
                end else begin
                    quot = {36'd0, coeff_reg, 8'd0} / period_filt;
                    if (quot > 64'hFFFF) quot = 64'hFFFF;
                end
                rpm_raw    = quot[15:0];
                rpm_smooth = smooth(rpm_smooth, {rpm_raw, 8'd0}, speed_gain);
            end
            edge_ticks = '0;
        end else if (edge_ticks != 16'hFFFF) begin
            edge_ticks = edge_ticks + 16'd1;
        end
        r.code = code;
        r.step = drive_step_of(code);
        if (r.step == STEP_STOP) rpm_raw = '0;
        r.rpm      = rpm_raw;
        r.rpm_filt = rpm_smooth[23:8];
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int got);
        if (exp_val != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s differs, expected %0d, got %0d", $time, name, exp_val, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_hall_result exp_res;
        in_acc  <= s_axis_tvalid && s_axis_tready;
        out_acc <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_commutation(s_axis_tdata[2:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %h arrived with none pending", $time, m_axis_tdata);
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("hall_code", int'(exp_res.code), int'(m_axis_tdata[2:0]));
                    check_field("drive_step", int'(exp_res.step), int'(m_axis_tdata[5:3]));
                    check_field("raw_speed", int'(exp_res.rpm), int'(m_axis_tdata[21:6]));
                    check_field("smoothed_speed", int'(exp_res.rpm_filt),
                                int'(m_axis_tdata[37:22]));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_acc)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (hall_samples.size() > 0) begin
                s_axis_tdata  <= {5'd0, hall_samples.pop_front()};
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // A long hold-off is started only while plenty of samples are still queued,
    // so that the block backs up and stops taking input.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_acc) begin
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 3);
                if (holds_done < 2 && results_seen >= 300 * (holds_done + 1)
                        && hall_samples.size() > 100) begin
                    rx_hold = 300;
                    holds_done++;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_ticks(input logic [2:0] code, input int count);
        repeat (count) hall_samples.push_back(code);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (hall_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SPEED_COEFF: coeff_reg  = data;
            CFG_COUNT_ALPHA: count_gain = data[15:0];
            CFG_SPEED_ALPHA: speed_gain = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Mostly clean rotations in either direction with random dwell, plus glitches
    // and stop codes.
    task automatic random_traffic(input int budget);
        int added;
        int pos;
        int len;
        int hold;
        bit fwd;
        bit slow;
        added = 0;
        while (added < budget) begin
            case ($urandom_range(0, 9))
                8: begin
                    hold = $urandom_range(1, 4);
                    repeat (hold) add_ticks(3'($urandom_range(0, 7)), 1);
                    added += hold;
                end
                9: begin
                    hold = $urandom_range(1, 3);
                    add_ticks($urandom_range(0, 1) ? 3'd7 : 3'd0, hold);
                    added += hold;
                end
                default: begin
                    fwd  = 1'($urandom_range(0, 1));
                    slow = ($urandom_range(0, 7) == 0);
                    pos  = $urandom_range(0, 5);
                    len  = $urandom_range(6, 24);
                    repeat (len) begin
                        hold = slow ? $urandom_range(8, 30) : $urandom_range(1, 6);
                        add_ticks(ROTATION[pos], hold);
                        added += hold;
                        pos = fwd ? (pos + 1) % 6 : (pos + 5) % 6;
                    end
                end
            endcase
        end
    endtask

    initial begin
        coeff_reg   = SPEED_COEFF_RST;
        count_gain  = COUNT_ALPHA_RST;
        speed_gain  = SPEED_ALPHA_RST;
        last_u_seen = 1'b0;
        edge_ticks  = '0;
        period_filt = '0;
        rpm_raw     = '0;
        rpm_smooth  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A rising U edge straight after reset divides by a zero period, then
        // every code appears once, then fast edges push the quotient past full scale.
        write_reg(CFG_UNUSED, 20'hFFFFF);
        add_ticks(3'd1, 1);
        add_ticks(3'd0, 1);
        for (int c = 2; c < 8; c++) add_ticks(3'(c), 1);
        add_ticks(3'd4, 1);
        add_ticks(3'd5, 1);
        add_ticks(3'd4, 1);
        add_ticks(3'd5, 1);
        add_ticks(3'd0, 2);
        wait_drained();

        write_reg(CFG_SPEED_COEFF, 20'hFFFFF);
        write_reg(CFG_COUNT_ALPHA, 20'h0FFFF);
        write_reg(CFG_SPEED_ALPHA, 20'h0FFFF);
        for (int i = 0; i < 12; i++) add_ticks(ROTATION[i % 6], 1);
        wait_drained();

        // A long dwell on one code gives a long period before the next rising edge.
        add_ticks(3'd4, 100);
        add_ticks(3'd5, 1);
        add_ticks(3'd1, 3);
        wait_drained();

        write_reg(CFG_SPEED_COEFF, 20'd1);
        write_reg(CFG_COUNT_ALPHA, 20'd0);
        write_reg(CFG_SPEED_ALPHA, 20'd0);
        for (int i = 0; i < 12; i++) add_ticks(ROTATION[(11 - i) % 6], 2);
        wait_drained();

        // Upper data bits must be dropped for the 16-bit gain registers.
        write_reg(CFG_COUNT_ALPHA, 20'hA0000 | 20'(COUNT_ALPHA_RST));
        write_reg(CFG_SPEED_ALPHA, 20'h50000 | 20'(SPEED_ALPHA_RST));
        write_reg(CFG_SPEED_COEFF, 20'(SPEED_COEFF_RST));
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_SPEED_COEFF, 20'(pick(1, 20'hFFFFF)));
                write_reg(CFG_COUNT_ALPHA, 20'(pick(0, 16'hFFFF)));
                write_reg(CFG_SPEED_ALPHA, 20'(pick(0, 16'hFFFF)));
            end
            random_traffic(130);
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/hcse_pkg.sv
rtl/core/hcse_alu.sv
rtl/core/hall_commutation_speed_estimator_top.sv
test/tb_hall_commutation_speed_estimator_top.sv
